FILE: rtl/core/e2q_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_pkg: shared definitions for the Euler angle to quaternion converter
// Widths, fixed-point constants, the CORDIC arctangent table and the
// sine/cosine pair that each angle lane hands to the merging stage.
// ----------------------------------------------------------------------------
package e2q_pkg;

   // Port field widths.
   localparam int ANGLE_W = 16;
   localparam int QUAT_W  = 16;

   // Internal Q.29 datapath and product widths.
   localparam int DATA_W  = 32;
   localparam int PROD_W  = 2 * DATA_W;
   localparam int FRAC    = 29;

   // Rounding of the Q.58 sum to Q.14.
   localparam int OUT_SHIFT = 44;
   localparam int SUM_W     = PROD_W + 1;
   localparam int RND_W     = SUM_W - OUT_SHIFT;

   // CORDIC configuration.
   localparam int CORDIC_STEPS_DEF = 14;
   localparam int ATAN_LEN         = 24;
   localparam int ATAN_IDX_W       = $clog2(ATAN_LEN);

   // Number of register stages in the merging unit.
   localparam int MERGE_LAT = 3;

   // Q.29 constants.
   localparam logic signed [DATA_W-1:0] GAIN_Q29    = 32'sd326016436;
   localparam logic signed [DATA_W-1:0] HALF_PI_Q29 = 32'sd843314857;
   localparam logic signed [DATA_W-1:0] PI_Q29      = 32'sd1686629713;

   // Saturation limits in Q1.14.
   localparam logic signed [RND_W-1:0] QUAT_MAX = 21'sd16384;
   localparam logic signed [RND_W-1:0] QUAT_MIN = -21'sd16384;

   // Sine and cosine of one half angle, Q.29.
   typedef struct packed {
      logic signed [DATA_W-1:0] cos_val;
      logic signed [DATA_W-1:0] sin_val;
   } sincos_type;

   // Arctangent of 2^-i in Q.29, rounded to nearest.
   function automatic logic signed [DATA_W-1:0] atan_q29(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [DATA_W-1:0] val;
      case (idx)
         5'd0:    val = 32'sd421657428;
         5'd1:    val = 32'sd248918915;
         5'd2:    val = 32'sd131521918;
         5'd3:    val = 32'sd66762579;
         5'd4:    val = 32'sd33510843;
         5'd5:    val = 32'sd16771757;
         5'd6:    val = 32'sd8387925;
         5'd7:    val = 32'sd4194219;
         5'd8:    val = 32'sd2097141;
         5'd9:    val = 32'sd1048575;
         5'd10:   val = 32'sd524288;
         5'd11:   val = 32'sd262144;
         5'd12:   val = 32'sd131072;
         5'd13:   val = 32'sd65536;
         5'd14:   val = 32'sd32768;
         5'd15:   val = 32'sd16384;
         5'd16:   val = 32'sd8192;
         5'd17:   val = 32'sd4096;
         5'd18:   val = 32'sd2048;
         5'd19:   val = 32'sd1024;
         5'd20:   val = 32'sd512;
         5'd21:   val = 32'sd256;
         5'd22:   val = 32'sd128;
         5'd23:   val = 32'sd64;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/euler_to_quaternion.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// euler_to_quaternion: Euler angles to attitude quaternion
// Three CORDIC lanes give the sines and cosines of the half angles; a
// merging unit forms the saturated Q1.14 quaternion components.
//
//   channel  direction  word layout (lowest bits first)
//   req      in         pitch_angle, roll_angle, yaw_angle (Q2.13 each)
//   rsp      out        quat_w, quat_x, quat_y, quat_z (Q1.14 each)
//
// One word is accepted per cycle while req_tready is high. A result passes the
// entry fold stage, which loads at the accepting edge, then one stage per CORDIC
// iteration, three merge stages, the queue write and the registered queue read
// before it is shown on rsp. Results wait in a power-of-two queue above the
// pipeline depth, and a credit count holds req_tready low only once that many
// words are outstanding. Reset clears the valid pipeline, the queue pointers,
// the output word valid and the credit count.
// ----------------------------------------------------------------------------
module euler_to_quaternion #(
   parameter int CORDIC_STEPS = e2q_pkg::CORDIC_STEPS_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [47:0] req_tdata,  // pitch_angle, roll_angle, yaw_angle
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [63:0] rsp_tdata   // quat_w, quat_x, quat_y, quat_z
);
   import e2q_pkg::*;

   localparam int LAT    = CORDIC_STEPS + 1 + MERGE_LAT;
   localparam int DEPTH  = 2 ** $clog2(LAT + 2);
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   logic req_acc, rsp_acc;
   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   // Angle lanes.
   sincos_type lane_x, lane_y, lane_z;

   e2q_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane_x (
      .clock  (clock),
      .angle  (req_tdata[ANGLE_W-1:0]),
      .sincos (lane_x)
   );
   e2q_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane_y (
      .clock  (clock),
      .angle  (req_tdata[2*ANGLE_W-1:ANGLE_W]),
      .sincos (lane_y)
   );
   e2q_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane_z (
      .clock  (clock),
      .angle  (req_tdata[3*ANGLE_W-1:2*ANGLE_W]),
      .sincos (lane_z)
   );

   // Merging unit.
   logic signed [QUAT_W-1:0] q_w, q_x, q_y, q_z;

   e2q_merge u_merge (
      .clock  (clock),
      .lane_x (lane_x),
      .lane_y (lane_y),
      .lane_z (lane_z),
      .quat_w (q_w),
      .quat_x (q_x),
      .quat_y (q_y),
      .quat_z (q_z)
   );

   // Valid bits that travel alongside the datapath.
   logic [LAT-1:0] vld_ff, vld_in;
   assign vld_in = {vld_ff[LAT-2:0], req_acc};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Output queue written as each result leaves the pipeline.
   logic [63:0]    fifo_mem [0:DEPTH-1];
   logic [PTR_W:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic           fifo_wr;
   logic           fifo_rd;
   logic           out_vld_ff, out_vld_in;
   logic [63:0]    out_data_ff;

   // A queued word moves to the output register whenever that register is free.
   assign fifo_wr    = vld_ff[LAT-1];
   assign fifo_rd    = (wr_ptr_ff != rd_ptr_ff) && (!out_vld_ff || rsp_acc);
   assign wr_ptr_in  = wr_ptr_ff + (PTR_W+1)'(fifo_wr);
   assign rd_ptr_in  = rd_ptr_ff + (PTR_W+1)'(fifo_rd);
   assign out_vld_in = fifo_rd || (out_vld_ff && !rsp_acc);

   always_ff @(posedge clock) begin
      if (fifo_wr) begin
         fifo_mem[wr_ptr_ff[PTR_W-1:0]] <= {q_z, q_y, q_x, q_w};
      end
   end

   // Registered read of the queue head into the output word.
   always_ff @(posedge clock) begin
      if (fifo_rd) begin
         out_data_ff <= fifo_mem[rd_ptr_ff[PTR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         out_vld_ff <= out_vld_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

   // Credit count of words accepted and not yet delivered.
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   assign cnt_in = cnt_ff + CNT_W'(req_acc) - CNT_W'(rsp_acc);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign req_tready = (cnt_ff < CNT_W'(DEPTH));

`ifndef SYNTHESIS
   // The credit count never exceeds the queue depth.
   assert property (@(posedge clock) disable iff (reset) cnt_ff <= CNT_W'(DEPTH))
      else $error("credit count above queue depth");

   // A result is never shown without an outstanding word behind it.
   assert property (@(posedge clock) disable iff (reset) rsp_tvalid |-> (cnt_ff != '0))
      else $error("result shown with no outstanding word");

   // The pipeline never writes into a full queue.
   assert property (@(posedge clock) disable iff (reset)
      fifo_wr |-> ((wr_ptr_ff - rd_ptr_ff) != (PTR_W+1)'(DEPTH)))
      else $error("write into full output queue");

   // The delivered w component stays within plus or minus one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[15:0]) <= 16'sd16384 &&
                      $signed(rsp_tdata[15:0]) >= -16'sd16384))
      else $error("quat_w out of range");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/e2q_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_cordic: one angle lane
// Halves the Q2.13 angle, folds it into +-pi/2 and runs a fully pipelined
// rotation-mode CORDIC, one iteration per register stage behind a registered
// entry stage; a new angle may enter every cycle.
// ----------------------------------------------------------------------------
module e2q_cordic #(
   parameter int CORDIC_STEPS = e2q_pkg::CORDIC_STEPS_DEF
) (
   input  wire                                    clock,
   input  wire  logic signed [e2q_pkg::ANGLE_W-1:0] angle,
   output e2q_pkg::sincos_type                    sincos
);
   import e2q_pkg::*;

   logic signed [DATA_W-1:0] x_ff [0:CORDIC_STEPS];
   logic signed [DATA_W-1:0] y_ff [0:CORDIC_STEPS];
   logic signed [DATA_W-1:0] z_ff [0:CORDIC_STEPS];
   logic                     flip_ff [0:CORDIC_STEPS];

   logic signed [DATA_W-1:0] z_in;
   logic signed [DATA_W-1:0] zfold_in;
   logic                     flip_in;

   // The half angle is the raw word read as Q.14, widened to Q.29.
   assign z_in = {{(DATA_W-ANGLE_W-15){angle[ANGLE_W-1]}}, angle, 15'b0};

   // Fold half angles beyond +-pi/2 back by pi; the result is negated later.
   always_comb begin
      zfold_in = z_in;
      flip_in  = 1'b0;
      if (z_in > HALF_PI_Q29) begin
         zfold_in = z_in - PI_Q29;
         flip_in  = 1'b1;
      end else if (z_in < -HALF_PI_Q29) begin
         zfold_in = z_in + PI_Q29;
         flip_in  = 1'b1;
      end
   end

   // Entry stage: gain-corrected start vector and folded angle.
   always_ff @(posedge clock) begin
      x_ff[0]    <= GAIN_Q29;
      y_ff[0]    <= '0;
      z_ff[0]    <= zfold_in;
      flip_ff[0] <= flip_in;
   end

   // One CORDIC iteration per stage; a non-negative residue turns counterclockwise.
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [DATA_W-1:0] dx;
      logic signed [DATA_W-1:0] dy;
      logic signed [DATA_W-1:0] ang;
      assign dx  = y_ff[i] >>> i;
      assign dy  = x_ff[i] >>> i;
      assign ang = atan_q29(ATAN_IDX_W'(i));
      always_ff @(posedge clock) begin
         if (!z_ff[i][DATA_W-1]) begin
            x_ff[i+1] <= x_ff[i] - dx;
            y_ff[i+1] <= y_ff[i] + dy;
            z_ff[i+1] <= z_ff[i] - ang;
         end else begin
            x_ff[i+1] <= x_ff[i] + dx;
            y_ff[i+1] <= y_ff[i] - dy;
            z_ff[i+1] <= z_ff[i] + ang;
         end
         flip_ff[i+1] <= flip_ff[i];
      end
   end

   // Undo the fold by negating both results.
   assign sincos.cos_val = flip_ff[CORDIC_STEPS] ? -x_ff[CORDIC_STEPS] : x_ff[CORDIC_STEPS];
   assign sincos.sin_val = flip_ff[CORDIC_STEPS] ? -y_ff[CORDIC_STEPS] : y_ff[CORDIC_STEPS];

endmodule
`default_nettype wire

FILE: rtl/core/e2q_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_merge: combines the three lanes into the quaternion
// Stage 1 forms the four pair products floored to Q.29, stage 2 the eight
// triple products in Q.58, stage 3 sums, rounds half up to Q1.14 and clamps.
// ----------------------------------------------------------------------------
module e2q_merge (
   input  wire                                    clock,
   input  e2q_pkg::sincos_type                    lane_x,
   input  e2q_pkg::sincos_type                    lane_y,
   input  e2q_pkg::sincos_type                    lane_z,
   output logic signed [e2q_pkg::QUAT_W-1:0]      quat_w,
   output logic signed [e2q_pkg::QUAT_W-1:0]      quat_x,
   output logic signed [e2q_pkg::QUAT_W-1:0]      quat_y,
   output logic signed [e2q_pkg::QUAT_W-1:0]      quat_z
);
   import e2q_pkg::*;

   // Saturating round of a Q.58 sum to Q1.14.
   function automatic logic signed [QUAT_W-1:0] to_q14(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] rnd;
      logic signed [RND_W-1:0] r;
      logic signed [RND_W-1:0] c;
      rnd = v + (SUM_W'(1) << (OUT_SHIFT - 1));
      r   = RND_W'(rnd >>> OUT_SHIFT);
      c   = r;
      if (r > QUAT_MAX) c = QUAT_MAX;
      if (r < QUAT_MIN) c = QUAT_MIN;
      return c[QUAT_W-1:0];
   endfunction

   // Stage 1: pair products of the x and y lanes.
   logic signed [PROD_W-1:0] cxcy_in, sxsy_in, sxcy_in, cxsy_in;
   logic signed [DATA_W-1:0] cxcy_ff, sxsy_ff, sxcy_ff, cxsy_ff;
   logic signed [DATA_W-1:0] cz_ff, sz_ff;

   assign cxcy_in = PROD_W'(lane_x.cos_val) * PROD_W'(lane_y.cos_val);
   assign sxsy_in = PROD_W'(lane_x.sin_val) * PROD_W'(lane_y.sin_val);
   assign sxcy_in = PROD_W'(lane_x.sin_val) * PROD_W'(lane_y.cos_val);
   assign cxsy_in = PROD_W'(lane_x.cos_val) * PROD_W'(lane_y.sin_val);

   always_ff @(posedge clock) begin
      cxcy_ff <= DATA_W'(cxcy_in >>> FRAC);
      sxsy_ff <= DATA_W'(sxsy_in >>> FRAC);
      sxcy_ff <= DATA_W'(sxcy_in >>> FRAC);
      cxsy_ff <= DATA_W'(cxsy_in >>> FRAC);
      cz_ff   <= lane_z.cos_val;
      sz_ff   <= lane_z.sin_val;
   end

   // Stage 2: triple products with the z lane, kept in Q.58.
   logic signed [PROD_W-1:0] w_a_ff, w_b_ff, x_a_ff, x_b_ff;
   logic signed [PROD_W-1:0] y_a_ff, y_b_ff, z_a_ff, z_b_ff;

   always_ff @(posedge clock) begin
      w_a_ff <= PROD_W'(cxcy_ff) * PROD_W'(cz_ff);
      w_b_ff <= PROD_W'(sxsy_ff) * PROD_W'(sz_ff);
      x_a_ff <= PROD_W'(sxcy_ff) * PROD_W'(cz_ff);
      x_b_ff <= PROD_W'(cxsy_ff) * PROD_W'(sz_ff);
      y_a_ff <= PROD_W'(cxsy_ff) * PROD_W'(cz_ff);
      y_b_ff <= PROD_W'(sxcy_ff) * PROD_W'(sz_ff);
      z_a_ff <= PROD_W'(cxcy_ff) * PROD_W'(sz_ff);
      z_b_ff <= PROD_W'(sxsy_ff) * PROD_W'(cz_ff);
   end

   // Stage 3: exact sums and differences, then round and clamp.
   logic signed [SUM_W-1:0] w_in, x_in, y_in, z_in;

   assign w_in = SUM_W'(w_a_ff) + SUM_W'(w_b_ff);
   assign x_in = SUM_W'(x_a_ff) - SUM_W'(x_b_ff);
   assign y_in = SUM_W'(y_a_ff) + SUM_W'(y_b_ff);
   assign z_in = SUM_W'(z_a_ff) - SUM_W'(z_b_ff);

   always_ff @(posedge clock) begin
      quat_w <= to_q14(w_in);
      quat_x <= to_q14(x_in);
      quat_y <= to_q14(y_in);
      quat_z <= to_q14(z_in);
   end

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Euler angle to quaternion converter
// A clocked driver streams angle triples from a queue into the block while a
// clocked monitor takes quaternion words and compares them, component by
// component, with values worked out by a bit-exact fixed-point CORDIC model.
// Both sides idle at random outside a stretch of full-rate words, and the
// receiver once holds off long enough to back the pipeline up into the input.
// ----------------------------------------------------------------------------
module tb_top;

   import e2q_pkg::ANGLE_W;
   import e2q_pkg::QUAT_W;

   localparam int STEPS       = e2q_pkg::CORDIC_STEPS_DEF;
   localparam int TABLE_LEN   = 24;
   localparam int Q_FRAC      = 29;
   localparam int LATENCY     = STEPS + 4;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_WORDS = 1900;
   localparam int HOLD_AT     = 1300;
   localparam int HOLD_CYCLES = 300;

   localparam longint Q29_GAIN    = 64'sd326016436;
   localparam longint Q29_HALF_PI = 64'sd843314857;
   localparam longint Q29_PI      = 64'sd1686629713;
   localparam longint UNIT_Q14    = 64'sd16384;

   localparam longint ATAN_Q29 [0:TABLE_LEN-1] = '{
      421657428, 248918915, 131521918, 66762579,
      33510843, 16771757, 8387925, 4194219,
      2097141, 1048575, 524288, 262144,
      131072, 65536, 32768, 16384,
      8192, 4096, 2048, 1024,
      512, 256, 128, 64
   };

   typedef struct {
      logic signed [ANGLE_W-1:0] pitch;
      logic signed [ANGLE_W-1:0] roll;
      logic signed [ANGLE_W-1:0] yaw;
   } angles_t;

   typedef struct {
      logic signed [QUAT_W-1:0] w;
      logic signed [QUAT_W-1:0] x;
      logic signed [QUAT_W-1:0] y;
      logic signed [QUAT_W-1:0] z;
   } quat_t;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [47:0] req_tdata  = '0;
   logic        rsp_tready = 1'b0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [63:0] rsp_tdata;

   angles_t angle_queue [$];
   quat_t   quat_expected [$];
   angles_t angles_on_bus;

   int   accepted_count = 0;
   int   received_count = 0;
   int   error_count    = 0;
   int   cycle_count    = 0;
   int   holdoff_left   = 0;
   bit   holdoff_done   = 1'b0;
   quat_t got_quat;
   quat_t want_quat;

   euler_to_quaternion #(.CORDIC_STEPS(STEPS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   // Sine and cosine of half the angle, Q.29, with folding past +-pi/2.
   function automatic void half_sin_cos(input logic signed [ANGLE_W-1:0] raw,
                                        output longint cos_q29,
                                        output longint sin_q29);
      longint acc_z;
      longint acc_x;
      longint acc_y;
      longint dx;
      longint dy;
      bit     folded;
      acc_z  = longint'(raw) * 64'sd32768;
      acc_x  = Q29_GAIN;
      acc_y  = 0;
      folded = 1'b0;
      if (acc_z > Q29_HALF_PI) begin
         acc_z  = acc_z - Q29_PI;
         folded = 1'b1;
      end else if (acc_z < -Q29_HALF_PI) begin
         acc_z  = acc_z + Q29_PI;
         folded = 1'b1;
      end
      for (int i = 0; i < STEPS && i < TABLE_LEN; i++) begin
         dx = acc_y >>> i;
         dy = acc_x >>> i;
         if (acc_z >= 0) begin
            acc_x = acc_x - dx;
            acc_y = acc_y + dy;
            acc_z = acc_z - ATAN_Q29[i];
         end else begin
            acc_x = acc_x + dx;
            acc_y = acc_y - dy;
            acc_z = acc_z + ATAN_Q29[i];
         end
      end
      cos_q29 = folded ? -acc_x : acc_x;
      sin_q29 = folded ? -acc_y : acc_y;
   endfunction

   // First product floored back to Q.29, second one left in Q.58.
   function automatic longint triple_prod(input longint a, input longint b, input longint c);
      return ((a * b) >>> Q_FRAC) * c;
   endfunction

   // Round half up from Q.58 to Q1.14 and saturate to +-1.0.
   function automatic logic signed [QUAT_W-1:0] round_to_q14(input longint v);
      longint r;
      r = (v + (longint'(1) << 43)) >>> 44;
      if (r > UNIT_Q14)
         r = UNIT_Q14;
      if (r < -UNIT_Q14)
         r = -UNIT_Q14;
      return r[QUAT_W-1:0];
   endfunction

   function automatic quat_t angles_to_quat(input angles_t a);
      longint cx, sx, cy, sy, cz, sz;
      quat_t  q;
      half_sin_cos(a.pitch, cx, sx);
      half_sin_cos(a.roll, cy, sy);
      half_sin_cos(a.yaw, cz, sz);
      q.w = round_to_q14(triple_prod(cx, cy, cz) + triple_prod(sx, sy, sz));
      q.x = round_to_q14(triple_prod(sx, cy, cz) - triple_prod(cx, sy, sz));
      q.y = round_to_q14(triple_prod(cx, sy, cz) + triple_prod(sx, cy, sz));
      q.z = round_to_q14(triple_prod(cx, cy, sz) - triple_prod(sx, sy, cz));
      return q;
   endfunction

   // Mostly in-range angles, some over the full word, some on the fold edge, some near zero.
   function automatic logic signed [ANGLE_W-1:0] random_angle();
      int pick;
      int val;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         val = int'($urandom_range(0, 51472)) - 25736;
      else if (pick < 85)
         val = int'($urandom_range(0, 65535)) - 32768;
      else if (pick < 93)
         val = ($urandom_range(0, 1) ? 25736 : -25736) + int'($urandom_range(0, 8)) - 4;
      else
         val = int'($urandom_range(0, 16)) - 8;
      return val[ANGLE_W-1:0];
   endfunction

   function automatic angles_t make_angles(input int p, input int r, input int y);
      angles_t a;
      a.pitch = p[ANGLE_W-1:0];
      a.roll  = r[ANGLE_W-1:0];
      a.yaw   = y[ANGLE_W-1:0];
      return a;
   endfunction

   // Cycle counter and watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Driver: offers angle words from the queue, idling at random.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            quat_expected.push_back(angles_to_quat(angles_on_bus));
            accepted_count = accepted_count + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (angle_queue.size() > 0 &&
                !((accepted_count < 700 || accepted_count >= 1000) &&
                  $urandom_range(0, 99) < 19)) begin
               angles_on_bus = angle_queue.pop_front();
               req_tdata     <= {angles_on_bus.yaw, angles_on_bus.roll, angles_on_bus.pitch};
               req_tvalid    <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each quaternion word and drives the ready side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_quat.w = rsp_tdata[15:0];
            got_quat.x = rsp_tdata[31:16];
            got_quat.y = rsp_tdata[47:32];
            got_quat.z = rsp_tdata[63:48];
            received_count = received_count + 1;
            if (quat_expected.size() == 0) begin
               $error("quaternion word with none expected: %h", rsp_tdata);
               error_count = error_count + 1;
            end else begin
               want_quat = quat_expected.pop_front();
               if (got_quat.w !== want_quat.w) begin
                  $error("quat_w expected %0d actual %0d", want_quat.w, got_quat.w);
                  error_count = error_count + 1;
               end
               if (got_quat.x !== want_quat.x) begin
                  $error("quat_x expected %0d actual %0d", want_quat.x, got_quat.x);
                  error_count = error_count + 1;
               end
               if (got_quat.y !== want_quat.y) begin
                  $error("quat_y expected %0d actual %0d", want_quat.y, got_quat.y);
                  error_count = error_count + 1;
               end
               if (got_quat.z !== want_quat.z) begin
                  $error("quat_z expected %0d actual %0d", want_quat.z, got_quat.z);
                  error_count = error_count + 1;
               end
            end
         end
         // One long hold-off lets the pipeline fill and stall the input.
         if (holdoff_left > 0) begin
            holdoff_left = holdoff_left - 1;
            rsp_tready <= 1'b0;
         end else if (!holdoff_done && received_count >= HOLD_AT) begin
            holdoff_done = 1'b1;
            holdoff_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (received_count >= 700 && received_count < 1000) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= 19);
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      // Zero angles: the CORDIC gain can push w past one, so it saturates.
      angle_queue.push_back(make_angles(0, 0, 0));
      angle_queue.push_back(make_angles(32767, 32767, 32767));
      angle_queue.push_back(make_angles(-32768, -32768, -32768));
      angle_queue.push_back(make_angles(32767, -32768, 0));
      angle_queue.push_back(make_angles(-1, -1, -1));
      angle_queue.push_back(make_angles(1, 1, 1));
      // Half angle just below and just past pi/2 on both sides.
      angle_queue.push_back(make_angles(25735, 25735, 25735));
      angle_queue.push_back(make_angles(25736, 25736, 25736));
      angle_queue.push_back(make_angles(-25735, -25735, -25735));
      angle_queue.push_back(make_angles(-25736, -25736, -25736));
      angle_queue.push_back(make_angles(25736, -25736, 0));
      // Single-axis quarter and half turns.
      angle_queue.push_back(make_angles(12868, 0, 0));
      angle_queue.push_back(make_angles(0, 12868, 0));
      angle_queue.push_back(make_angles(0, 0, 12868));
      angle_queue.push_back(make_angles(-12868, 0, 0));
      angle_queue.push_back(make_angles(0, -12868, 0));
      angle_queue.push_back(make_angles(0, 0, -12868));
      angle_queue.push_back(make_angles(25736, 0, 0));
      angle_queue.push_back(make_angles(0, 25736, 0));
      angle_queue.push_back(make_angles(0, 0, -25736));
      angle_queue.push_back(make_angles(21845, -10923, 5461));
      angle_queue.push_back(make_angles(-21846, 10922, -5462));
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         angle_queue.push_back(make_angles(random_angle(), random_angle(), random_angle()));
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (angle_queue.size() > 0 || req_tvalid)
         @(posedge clock);
      while (quat_expected.size() > 0)
         @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/e2q_pkg.sv
rtl/core/e2q_cordic.sv
rtl/core/e2q_merge.sv
rtl/core/euler_to_quaternion.sv
dv/tb_top.sv
